FILE: sv/vns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vns_pkg;

    // field widths
    localparam int COORD_X_W  = 7;
    localparam int COORD_Y_W  = 5;
    localparam int COORD_Z_W  = 5;
    localparam int VAL_W      = 32;
    localparam int SIZE_X_W   = 8;
    localparam int SIZE_YZ_W  = 6;
    localparam int WEIGHT_W   = 17;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 96;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // neighbour sum: up to 26 signed 32-bit terms
    localparam int MAX_NB = 26;
    localparam int CNT_W  = 5;
    localparam int MAG_W  = 36;
    localparam int SUM_W  = MAG_W + 1;

    // coordinate compare width, covers every grid bound and a wrapped -1
    localparam int CMP_W = 12;

    // register reset values
    localparam logic [SIZE_X_W-1:0]  GRID_X_RST = 8'd100;
    localparam logic [SIZE_YZ_W-1:0] GRID_Y_RST = 6'd30;
    localparam logic [SIZE_YZ_W-1:0] GRID_Z_RST = 6'd30;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RST = 17'h10000;

    // parameter defaults
    localparam int MAX_X_DEF     = 128;
    localparam int MAX_Y_DEF     = 32;
    localparam int MAX_Z_DEF     = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_X = 2'd0,
        CFG_GRID_Y = 2'd1,
        CFG_GRID_Z = 2'd2,
        CFG_WEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_WAIT,
        ST_MUL,
        ST_ADD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/vns_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, unsigned magnitude by count.
module vns_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vns_pkg::div_req_t req,
    output vns_pkg::div_rsp_t      rsp
);
    import vns_pkg::*;

    localparam int STEP_W = $clog2(MAG_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dsr_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              trial_ge;
    logic [CNT_W-1:0]  rem_next;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        trial_ge  = (trial >= {1'b0, dsr_reg});
        trial_sub = trial - {1'b0, dsr_reg};
        // remainder stays below the divisor, so five bits hold it
        rem_next  = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(MAG_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (req.divisor != '0))
        else $error("divider started with zero count");

endmodule

`default_nettype wire

FILE: sv/voxel_neighbour_smoothing.sv
`timescale 1ns / 1ps
`default_nettype none

// Write: IDLE, WRITE, back to IDLE; out-of-grid read: IDLE, CHECK, RESULT, back to IDLE.
// In-grid read, in order: center read, 27-step scan, drain, then per component a division,
// a multiply and an add, then RESULT; the next request is taken back in IDLE.
// No neighbours: division skipped. One request at a time; the result register holds a
// finished result while the next request is taken, and a full one stalls the block.
// rst_n (async, active low) clears control and loads register defaults, not voxel memory.
module voxel_neighbour_smoothing #(
    parameter int MAX_X     = vns_pkg::MAX_X_DEF,
    parameter int MAX_Y     = vns_pkg::MAX_Y_DEF,
    parameter int MAX_Z     = vns_pkg::MAX_Z_DEF,
    parameter int FRAC_BITS = vns_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [vns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vns_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // coord_x, coord_y, coord_z, value_x, value_y, value_z, zero pad
    input  wire logic [vns_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // op
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // smooth_x, smooth_y, smooth_z
    output logic [vns_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // out_of_grid
    output logic                                  m_axis_tuser
);
    import vns_pkg::*;

    localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PLANE  = MAX_X * MAX_Y;
    localparam int PROD_W = WEIGHT_W + 1 + VAL_W + 1;
    localparam int RES_W  = PROD_W + 1;
    localparam int VEC_W  = 3 * VAL_W;

    localparam logic [CMP_W-1:0] LIM_X = CMP_W'(MAX_X);
    localparam logic [CMP_W-1:0] LIM_Y = CMP_W'(MAX_Y);
    localparam logic [CMP_W-1:0] LIM_Z = CMP_W'(MAX_Z);

    localparam logic signed [RES_W-1:0] SAT_MAX =
        {{(RES_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_MIN =
        {{(RES_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    // configuration
    logic [SIZE_X_W-1:0]  grid_x_reg;
    logic [SIZE_YZ_W-1:0] grid_y_reg;
    logic [SIZE_YZ_W-1:0] grid_z_reg;
    logic [WEIGHT_W-1:0]  weight_reg;

    // control
    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   rd_valid_reg;
    logic   rd_center_reg;

    // request and work registers
    logic [COORD_X_W-1:0]     cx_reg;
    logic [COORD_Y_W-1:0]     cy_reg;
    logic [COORD_Z_W-1:0]     cz_reg;
    logic [VEC_W-1:0]         val_reg;
    logic [1:0]               dx_reg;
    logic [1:0]               dy_reg;
    logic [1:0]               dz_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [VAL_W-1:0]  old_reg [3];
    logic [1:0]               comp_reg;
    logic signed [VAL_W-1:0]  mean_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]         res_reg [3];
    logic                     flag_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic                     out_flag_reg;

    // voxel memory
    logic [VEC_W-1:0] mem [DEPTH];
    logic [VEC_W-1:0] mem_rdata_reg;

    logic [CMP_W-1:0]  nx;
    logic [CMP_W-1:0]  ny;
    logic [CMP_W-1:0]  nz;
    logic              nb_in_grid;
    logic              is_center;
    logic              scan_last;
    logic [ADDR_W-1:0] addr;

    logic mem_we;
    logic mem_re;
    logic out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [SUM_W-1:0] sum_sel;
    logic signed [VAL_W-1:0] old_sel;
    logic                    sum_neg;
    logic signed [SUM_W-1:0] sum_abs;
    logic signed [SUM_W-1:0] quo_s;
    logic signed [SUM_W-1:0] mean_full;
    logic signed [VAL_W:0]   diff;
    logic signed [RES_W-1:0] blend;
    logic [VAL_W-1:0]        blend_sat;

    // offsets run 0..2 for -1..+1; a wrapped -1 is above every bound
    always_comb
    begin
        nx = CMP_W'(cx_reg) + CMP_W'(dx_reg) - CMP_W'(1);
        ny = CMP_W'(cy_reg) + CMP_W'(dy_reg) - CMP_W'(1);
        nz = CMP_W'(cz_reg) + CMP_W'(dz_reg) - CMP_W'(1);
        nb_in_grid = (nx < CMP_W'(grid_x_reg)) && (nx < LIM_X)
                  && (ny < CMP_W'(grid_y_reg)) && (ny < LIM_Y)
                  && (nz < CMP_W'(grid_z_reg)) && (nz < LIM_Z);
        is_center = (dx_reg == 2'd1) && (dy_reg == 2'd1) && (dz_reg == 2'd1);
        scan_last = (dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2);
        addr = ADDR_W'(nz) * ADDR_W'(PLANE) + ADDR_W'(ny) * ADDR_W'(MAX_X)
             + ADDR_W'(nx);
    end

    always_comb
    begin
        sum_sel   = sum_reg[comp_reg];
        old_sel   = old_reg[comp_reg];
        sum_neg   = sum_sel[SUM_W-1];
        sum_abs   = sum_neg ? -sum_sel : sum_sel;
        quo_s     = $signed({1'b0, div_rsp.quotient});
        mean_full = sum_neg ? -quo_s : quo_s;
        diff      = {mean_reg[VAL_W-1], mean_reg} - {old_sel[VAL_W-1], old_sel};
        blend     = RES_W'(old_sel) + RES_W'(prod_reg >>> FRAC_BITS);
        if (blend > SAT_MAX)
            blend_sat = SAT_MAX[VAL_W-1:0];
        else if (blend < SAT_MIN)
            blend_sat = SAT_MIN[VAL_W-1:0];
        else
            blend_sat = blend[VAL_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        s_axis_tready    = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_abs[MAG_W-1:0];
        div_req.divisor  = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = (s_axis_tuser == OP_WRITE) ? ST_WRITE : ST_CHECK;
            end
            ST_WRITE:
            begin
                mem_we     = nb_in_grid;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                mem_re     = nb_in_grid;
                state_next = nb_in_grid ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN:
            begin
                mem_re = nb_in_grid && !is_center;
                if (scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_MUL;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = (comp_reg == 2'd2) ? ST_RESULT : ST_DIV;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            grid_x_reg    <= GRID_X_RST;
            grid_y_reg    <= GRID_Y_RST;
            grid_z_reg    <= GRID_Z_RST;
            weight_reg    <= WEIGHT_RST;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= mem_re;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GRID_X: grid_x_reg <= cfg_data[SIZE_X_W-1:0];
                    CFG_GRID_Y: grid_y_reg <= cfg_data[SIZE_YZ_W-1:0];
                    CFG_GRID_Z: grid_z_reg <= cfg_data[SIZE_YZ_W-1:0];
                    CFG_WEIGHT: weight_reg <= cfg_data[WEIGHT_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_center_reg <= (state_reg == ST_CHECK);
        case (state_reg)
            ST_IDLE:
            begin
                cx_reg  <= s_axis_tdata[COORD_X_W-1:0];
                cy_reg  <= s_axis_tdata[COORD_X_W +: COORD_Y_W];
                cz_reg  <= s_axis_tdata[COORD_X_W+COORD_Y_W +: COORD_Z_W];
                val_reg <= s_axis_tdata[COORD_X_W+COORD_Y_W+COORD_Z_W +: VEC_W];
                // center offsets: write and range check use the request voxel
                dx_reg  <= 2'd1;
                dy_reg  <= 2'd1;
                dz_reg  <= 2'd1;
            end
            ST_CHECK:
            begin
                dx_reg   <= 2'd0;
                dy_reg   <= 2'd0;
                dz_reg   <= 2'd0;
                cnt_reg  <= '0;
                comp_reg <= 2'd0;
                flag_reg <= !nb_in_grid;
                for (int c = 0; c < 3; c++)
                    res_reg[c] <= '0;
            end
            ST_SCAN:
            begin
                if (nb_in_grid && !is_center)
                    cnt_reg <= cnt_reg + CNT_W'(1);
                if (dx_reg != 2'd2)
                    dx_reg <= dx_reg + 2'd1;
                else
                begin
                    dx_reg <= 2'd0;
                    if (dy_reg != 2'd2)
                        dy_reg <= dy_reg + 2'd1;
                    else
                    begin
                        dy_reg <= 2'd0;
                        dz_reg <= dz_reg + 2'd1;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    mean_reg <= old_sel;
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                    mean_reg <= mean_full[VAL_W-1:0];
            end
            ST_MUL:
            begin
                prod_reg <= $signed({1'b0, weight_reg}) * diff;
            end
            ST_ADD:
            begin
                res_reg[comp_reg] <= blend_sat;
                comp_reg          <= comp_reg + 2'd1;
            end
            default:
            begin
            end
        endcase

        // returning memory words: center first, then neighbours
        if (state_reg == ST_CHECK)
        begin
            for (int c = 0; c < 3; c++)
                sum_reg[c] <= '0;
        end
        else if (rd_valid_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rd_center_reg)
                    old_reg[c] <= mem_rdata_reg[c*VAL_W +: VAL_W];
                else
                    sum_reg[c] <= sum_reg[c]
                                + SUM_W'($signed(mem_rdata_reg[c*VAL_W +: VAL_W]));
            end
        end

        if (out_load)
        begin
            out_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
            out_flag_reg <= flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= val_reg;
        if (mem_re)
            mem_rdata_reg <= mem[addr];
    end

    vns_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(MAX_NB)))
        else $error("neighbour count above 26");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten while pending");

    a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SCAN || state_reg == ST_CHECK))
        else $error("memory read data outside a scan");

endmodule

`default_nettype wire

FILE: bench/voxel_neighbour_smoothing_tb.sv
`timescale 1ns / 1ps

module voxel_neighbour_smoothing_tb;
    import vns_pkg::*;

    localparam int GRID_MAX_X     = MAX_X_DEF;
    localparam int GRID_MAX_Y     = MAX_Y_DEF;
    localparam int GRID_MAX_Z     = MAX_Z_DEF;
    localparam int VOX_DEPTH      = GRID_MAX_X * GRID_MAX_Y * GRID_MAX_Z;
    localparam int COORD_X_MAX    = (1 << COORD_X_W) - 1;
    localparam int COORD_Y_MAX    = (1 << COORD_Y_W) - 1;
    localparam int COORD_Z_MAX    = (1 << COORD_Z_W) - 1;
    localparam int W_FULL         = 65536;
    localparam int W_MAX          = 131071;
    localparam int PHASE_ITEMS    = 165;
    localparam int NUM_PHASES     = 11;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 10;
    localparam int END_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam longint      SAT_HI  = 64'sd2147483647;
    localparam longint      SAT_LO  = -64'sd2147483648;

    // smooth_x in the low bits, out_of_grid on top
    typedef struct packed {
        logic        oog;
        logic [31:0] sz;
        logic [31:0] sy;
        logic [31:0] sx;
    } smooth_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_GRID_X;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // coord_x, coord_y, coord_z, value_x, value_y, value_z, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // op
    logic                  s_axis_tuser  = OP_WRITE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // smooth_x, smooth_y, smooth_z
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // out_of_grid
    logic                  m_axis_tuser;

    // shadow of the voxel memory and the registers
    bit [95:0]   vox_mem     [VOX_DEPTH];
    bit          vox_written [VOX_DEPTH];
    int          grid_x = int'(GRID_X_RST);
    int          grid_y = int'(GRID_Y_RST);
    int          grid_z = int'(GRID_Z_RST);
    int          weight = int'(WEIGHT_RST);
    smooth_t     smooth_expect_q [$];

    int          error_count;
    int          results_checked;
    int          writes_sent;
    int          writes_dropped;
    int          reads_sent;
    bit          no_idle;
    int unsigned hold_requests;
    int unsigned holds_done;
    int unsigned rx_hold_cnt;
    int unsigned rx_run;
    int unsigned idle_cycles;

    voxel_neighbour_smoothing dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= 40)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int bound_of(int size, int max_size);
        return (size < max_size) ? size : max_size;
    endfunction

    function automatic bit in_grid(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 &&
               x < bound_of(grid_x, GRID_MAX_X) &&
               y < bound_of(grid_y, GRID_MAX_Y) &&
               z < bound_of(grid_z, GRID_MAX_Z);
    endfunction

    function automatic bit grid_has_inside();
        return grid_x != 0 && grid_y != 0 && grid_z != 0;
    endfunction

    function automatic bit grid_has_outside();
        return grid_x < GRID_MAX_X || grid_y < GRID_MAX_Y || grid_z < GRID_MAX_Z;
    endfunction

    function automatic int vox_addr(int x, int y, int z);
        return (z * GRID_MAX_Y + y) * GRID_MAX_X + x;
    endfunction

    // mean of the in-grid neighbours, blended toward it and saturated
    function automatic smooth_t smooth_voxel(int x, int y, int z);
        smooth_t   res;
        longint    sum [3];
        longint    old;
        longint    mean;
        longint    blended;
        int        cnt;
        int        self_a;
        int        dx;
        int        dy;
        int        dz;
        int        c;
        bit [95:0] nb;
        res = '0;
        if (!in_grid(x, y, z))
        begin
            res.oog = 1'b1;
            return res;
        end
        for (c = 0; c < 3; c++)
            sum[c] = 0;
        cnt = 0;
        for (dz = -1; dz <= 1; dz++)
            for (dy = -1; dy <= 1; dy++)
                for (dx = -1; dx <= 1; dx++)
                    if ((dx != 0 || dy != 0 || dz != 0) && in_grid(x + dx, y + dy, z + dz))
                    begin
                        nb = vox_mem[vox_addr(x + dx, y + dy, z + dz)];
                        for (c = 0; c < 3; c++)
                            sum[c] += longint'($signed(nb[c*32 +: 32]));
                        cnt++;
                    end
        self_a = vox_addr(x, y, z);
        for (c = 0; c < 3; c++)
        begin
            old  = longint'($signed(vox_mem[self_a][c*32 +: 32]));
            // a lone voxel keeps its own value
            mean = (cnt != 0) ? sum[c] / cnt : old;
            blended = old + ((longint'(weight) * (mean - old)) >>> FRAC_BITS_DEF);
            if (blended > SAT_HI)
                blended = SAT_HI;
            else if (blended < SAT_LO)
                blended = SAT_LO;
            res[c*32 +: 32] = blended[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [95:0] rand_vals();
        return {rand_value(), rand_value(), rand_value()};
    endfunction

    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int near_edge(int b);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, (b > 3) ? 2 : b - 1);
            1: return $urandom_range((b > 3) ? b - 3 : 0, b - 1);
            default: return $urandom_range(0, b - 1);
        endcase
    endfunction

    function automatic string comp_name(int c);
        case (c)
            0: return "smooth_x";
            1: return "smooth_y";
            default: return "smooth_z";
        endcase
    endfunction

    // valid stays high into the next request when there is no gap
    task automatic send_request(op_t op, int x, int y, int z, logic [95:0] vals);
        int unsigned gap;
        int          a;
        gap = no_idle ? 0 : rand_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, vals, 5'(z), 5'(y), 7'(x)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == OP_WRITE)
        begin
            writes_sent++;
            if (in_grid(x, y, z))
            begin
                a = vox_addr(x, y, z);
                vox_mem[a]     = vals;
                vox_written[a] = 1'b1;
            end
            else
                writes_dropped++;
        end
        else
        begin
            reads_sent++;
            smooth_expect_q.insert(smooth_expect_q.size(), smooth_voxel(x, y, z));
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (smooth_expect_q.size() != 0);
        // a trailing write gives no result
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_grid(int sx, int sy, int sz, int w);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_X;
        cfg_data  <= CFG_DATA_W'(sx);
        @(posedge clk);
        cfg_index <= CFG_GRID_Y;
        cfg_data  <= CFG_DATA_W'(sy);
        @(posedge clk);
        cfg_index <= CFG_GRID_Z;
        cfg_data  <= CFG_DATA_W'(sz);
        @(posedge clk);
        cfg_index <= CFG_WEIGHT;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_x = sx & 'hff;
        grid_y = sy & 'h3f;
        grid_z = sz & 'h3f;
        weight = w & 'h1ffff;
    endtask

    task automatic pick_inside(output int x, output int y, output int z);
        x = near_edge(bound_of(grid_x, GRID_MAX_X));
        y = near_edge(bound_of(grid_y, GRID_MAX_Y));
        z = near_edge(bound_of(grid_z, GRID_MAX_Z));
    endtask

    task automatic pick_outside(output int x, output int y, output int z);
        int bx;
        int by;
        int bz;
        int axis;
        bx = bound_of(grid_x, GRID_MAX_X);
        by = bound_of(grid_y, GRID_MAX_Y);
        bz = bound_of(grid_z, GRID_MAX_Z);
        x  = $urandom_range(0, COORD_X_MAX);
        y  = $urandom_range(0, COORD_Y_MAX);
        z  = $urandom_range(0, COORD_Z_MAX);
        do
            axis = $urandom_range(0, 2);
        while (!((axis == 0 && bx <= COORD_X_MAX) || (axis == 1 && by <= COORD_Y_MAX) ||
                 (axis == 2 && bz <= COORD_Z_MAX)));
        case (axis)
            0: x = $urandom_range(bx, COORD_X_MAX);
            1: y = $urandom_range(by, COORD_Y_MAX);
            default: z = $urandom_range(bz, COORD_Z_MAX);
        endcase
    endtask

    // fill in any unwritten voxel of the neighbourhood, then read the centre
    task automatic read_with_neighbours(int x, int y, int z, inout int sent);
        int dx;
        int dy;
        int dz;
        for (dz = -1; dz <= 1; dz++)
            for (dy = -1; dy <= 1; dy++)
                for (dx = -1; dx <= 1; dx++)
                    if (in_grid(x + dx, y + dy, z + dz) &&
                        !vox_written[vox_addr(x + dx, y + dy, z + dz)])
                    begin
                        send_request(OP_WRITE, x + dx, y + dy, z + dz, rand_vals());
                        sent++;
                    end
        send_request(OP_READ, x, y, z, rand_vals());
        sent++;
    endtask

    task automatic run_phase(int target);
        int sent;
        int kind;
        int x;
        int y;
        int z;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(0, 99);
            kind = (kind < 40) ? 0 : (kind < 80) ? 1 : (kind < 92) ? 2 : 3;
            if (kind < 2 && !grid_has_inside())
                kind = 2;
            if (kind >= 2 && !grid_has_outside())
                kind = 1;
            case (kind)
                0:
                begin
                    pick_inside(x, y, z);
                    send_request(OP_WRITE, x, y, z, rand_vals());
                    sent++;
                end
                1:
                begin
                    pick_inside(x, y, z);
                    read_with_neighbours(x, y, z, sent);
                end
                2:
                begin
                    pick_outside(x, y, z);
                    send_request(OP_READ, x, y, z, rand_vals());
                    sent++;
                end
                default:
                begin
                    // dropped by the block
                    pick_outside(x, y, z);
                    send_request(OP_WRITE, x, y, z, rand_vals());
                    sent++;
                end
            endcase
        end
    endtask

    task automatic test_directed_cases();
        int x;
        int y;
        int z;
        // reset bounds are 100 x 30 x 30
        send_request(OP_READ, 100, 0, 0, rand_vals());
        send_request(OP_READ, 0, 30, 0, rand_vals());
        send_request(OP_READ, COORD_X_MAX, COORD_Y_MAX, COORD_Z_MAX, '0);
        send_request(OP_WRITE, COORD_X_MAX, COORD_Y_MAX, COORD_Z_MAX, '1);
        // single voxel: no neighbours
        wait_idle();
        program_grid(1, 1, 1, W_FULL);
        send_request(OP_WRITE, 0, 0, 0, {32'h0001_8000, VAL_MIN, VAL_MAX});
        send_request(OP_READ, 0, 0, 0, '0);
        send_request(OP_READ, 1, 0, 0, '0);
        // empty grid
        wait_idle();
        program_grid(0, 0, 0, W_FULL);
        send_request(OP_WRITE, 0, 0, 0, '1);
        send_request(OP_READ, 0, 0, 0, '1);
        // overdriven weight: saturate high on x, low on y at the origin
        wait_idle();
        program_grid(2, 2, 2, W_MAX);
        for (z = 0; z < 2; z++)
            for (y = 0; y < 2; y++)
                for (x = 0; x < 2; x++)
                    if (x + y + z == 0)
                        send_request(OP_WRITE, x, y, z, {32'd0, VAL_MAX, VAL_MIN});
                    else
                        send_request(OP_WRITE, x, y, z, {rand_value(), VAL_MIN, VAL_MAX});
        send_request(OP_READ, 0, 0, 0, '0);
        send_request(OP_READ, 1, 1, 1, '0);
        // zero weight returns the stored voxel
        wait_idle();
        program_grid(2, 2, 2, 0);
        send_request(OP_READ, 1, 0, 1, '0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        int x;
        int y;
        int z;
        int i;
        wait_idle();
        program_grid(3, 3, 3, 32768);
        no_idle = 1'b1;
        for (z = 0; z < 3; z++)
            for (y = 0; y < 3; y++)
                for (x = 0; x < 3; x++)
                    send_request(OP_WRITE, x, y, z, rand_vals());
        // receiver stalls while reads keep coming, so the input backs up
        hold_requests++;
        for (i = 0; i < 10; i++)
            send_request(OP_READ, $urandom_range(0, 2), $urandom_range(0, 2),
                         $urandom_range(0, 2), rand_vals());
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_phases();
        int p;
        int sx;
        int sy;
        int sz;
        int w;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            sx = $urandom_range(1, 6);
            sy = $urandom_range(1, 6);
            sz = $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: w = 0;
                1: w = W_FULL;
                2: w = W_MAX;
                default: w = $urandom_range(0, W_MAX);
            endcase
            case (p)
                0: begin sx = 3;   sy = 3;  sz = 3;  w = W_FULL; end
                1: begin sx = 255; sy = 63; sz = 63; end
                2: begin sx = 128; sy = 32; sz = 32; w = 0; end
                3: begin sx = 1;   sy = 1;  sz = 1;  w = W_MAX; end
                4: begin sx = 0;   sy = 5;  sz = 5; end
                5: begin sx = 2;   sy = 32; sz = 2;  w = W_MAX; end
                6: begin sx = 100; sy = 30; sz = 30; w = W_FULL; end
                default: ;
            endcase
            wait_idle();
            program_grid(sx, sy, sz, w);
            no_idle = (p == 2 || p == 8);
            run_phase(PHASE_ITEMS);
        end
        no_idle = 1'b0;
    endtask

    // result side: random ready, plus a long hold when one is requested
    always @(posedge clk)
    begin
        if (holds_done < hold_requests && rx_hold_cnt == 0)
        begin
            rx_hold_cnt = HOLD_CYCLES;
            holds_done++;
        end
        if (rx_hold_cnt != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_cnt = rx_hold_cnt - 1;
            if (rx_hold_cnt == 0)
                rx_run = 0;
        end
        else if (no_idle)
            m_axis_tready <= 1'b1;
        else if (rx_run != 0)
            rx_run = rx_run - 1;
        else if ($urandom_range(0, 2) != 0)
        begin
            m_axis_tready <= 1'b1;
            rx_run = $urandom_range(0, 15);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            rx_run = rand_gap();
        end
    end

    always @(posedge clk)
    begin : check_results
        smooth_t exp_res;
        int      c;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (smooth_expect_q.size() == 0)
                report_error("result with no read request waiting");
            else
            begin
                exp_res = smooth_expect_q.pop_front();
                for (c = 0; c < 3; c++)
                    if (m_axis_tdata[c*32 +: 32] !== exp_res[c*32 +: 32])
                        report_error($sformatf("result %0d %s: got %h, expected %h",
                                               results_checked, comp_name(c),
                                               m_axis_tdata[c*32 +: 32], exp_res[c*32 +: 32]));
                if (m_axis_tuser !== exp_res.oog)
                    report_error($sformatf("result %0d out_of_grid: got %b, expected %b",
                                           results_checked, m_axis_tuser, exp_res.oog));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no request or result moved for %0d cycles", idle_cycles);
                $display("** voxel_neighbour_smoothing: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_backpressure();
        test_random_phases();
        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (smooth_expect_q.size() != 0)
            report_error($sformatf("%0d read results never arrived", smooth_expect_q.size()));
        $display("run: %0d writes (%0d outside the grid), %0d reads, %0d results checked",
                 writes_sent, writes_dropped, reads_sent, results_checked);
        $display("grids from empty to over-range, weights 0 to 131071, stalls on both sides");
        if (error_count == 0)
            $display("** voxel_neighbour_smoothing: PASSED **");
        else
            $display("** voxel_neighbour_smoothing: FAILED **");
        $finish;
    end

endmodule
